[design/integer_to_ascii_formatter_core_macros.svh]
// Assertion helpers, clocked on clk and held off during rst.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication.
`define ITAF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ITAF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/itaf_pkg.sv]
`default_nettype none

package itaf_pkg;

  localparam logic [1:0] ACT_SDEC = 2'd0;
  localparam logic [1:0] ACT_UDEC = 2'd1;
  localparam logic [1:0] ACT_HEX  = 2'd2;
  localparam logic [1:0] ACT_PTR  = 2'd3;

  localparam logic [1:0] K_DEC = 2'd0;
  localparam logic [1:0] K_HEX = 2'd1;
  localparam logic [1:0] K_PTR = 2'd2;
  localparam logic [1:0] K_NIL = 2'd3;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam int CountW = 31;
  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  typedef struct packed {
    logic [1:0] kind;
    logic       upper;
    logic       neg;
  } itaf_ctrl_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = CH_0 + {4'd0, d};
    end else if (up) begin
      r = CH_UA + {4'd0, d - 4'd10};
    end else begin
      r = CH_LA + {4'd0, d - 4'd10};
    end
    return r;
  endfunction

  function automatic logic [2:0] pfx_len(input logic [1:0] kind, input logic neg);
    logic [2:0] r;
    case (kind)
      K_DEC:   r = neg ? 3'd1 : 3'd0;
      K_PTR:   r = 3'd2;
      K_NIL:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pfx_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] r;
    case (kind)
      K_DEC: r = CH_MINUS;
      K_PTR: r = (idx == 3'd0) ? CH_0 : CH_X;
      K_NIL: begin
        case (idx)
          3'd0:    r = CH_LPAR;
          3'd1:    r = CH_N;
          3'd2:    r = CH_I;
          3'd3:    r = CH_L;
          default: r = CH_RPAR;
        endcase
      end
      default: r = CH_0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/itaf_front.sv]
`default_nettype none

module itaf_front
  import itaf_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_valid,
  output logic                        s_ready,
  input  wire logic [1:0]             s_action,
  input  wire logic                   s_upper,
  input  wire logic [63:0]            s_value,
  output logic                        q_valid,
  output itaf_ctrl_t                  q_ctrl,
  output logic [VALUE_WIDTH-1:0]      q_mag,
  input  wire logic                   q_pop
);

  logic [VALUE_WIDTH-1:0] v;
  itaf_ctrl_t             c_ctrl;
  logic [VALUE_WIDTH-1:0] c_mag;

  itaf_ctrl_t             ctrl_mem [2];
  logic [VALUE_WIDTH-1:0] mag_mem  [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             level;
  logic                   push;

  always_comb begin
    v            = s_value[VALUE_WIDTH-1:0];
    c_ctrl.kind  = K_DEC;
    c_ctrl.upper = 1'b0;
    c_ctrl.neg   = 1'b0;
    c_mag        = v;
    case (s_action)
      ACT_SDEC: begin
        c_ctrl.neg = v[VALUE_WIDTH-1];
        if (v[VALUE_WIDTH-1]) begin
          c_mag = ~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1};
        end
      end
      ACT_UDEC: c_ctrl.kind = K_DEC;
      ACT_HEX: begin
        c_ctrl.kind  = K_HEX;
        c_ctrl.upper = s_upper;
      end
      ACT_PTR:  c_ctrl.kind = (v == '0) ? K_NIL : K_PTR;
      default:  c_ctrl.kind = K_DEC;
    endcase
  end

  assign s_ready = (level != 2'd2);
  assign push    = s_valid && s_ready;
  assign q_valid = (level != 2'd0);
  assign q_ctrl  = ctrl_mem[rd_ptr];
  assign q_mag   = mag_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_mem[wr_ptr] <= c_ctrl;
      mag_mem[wr_ptr]  <= c_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      level <= level + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

[design/itaf_back.sv]
`default_nettype none

module itaf_back
  import itaf_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire itaf_ctrl_t             q_ctrl,
  input  wire logic [VALUE_WIDTH-1:0] q_mag,
  output logic                        q_pop,
  output logic                        m_valid,
  input  wire logic                   m_ready,
  output logic [7:0]                  m_char,
  output logic                        m_last,
  output logic [CountW-1:0]           m_count
);

  localparam int DecDigs = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HexDigs = (VALUE_WIDTH + 3) / 4;
  localparam int Digs    = (DecDigs > HexDigs) ? DecDigs : HexDigs;
  localparam int BcdW    = 4 * Digs;
  localparam int IterW   = $clog2(VALUE_WIDTH + 1);
  localparam int RemW    = $clog2(Digs + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_PFX  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]             state, state_next;
  itaf_ctrl_t             ctrl, ctrl_next;
  logic [VALUE_WIDTH-1:0] bin, bin_next;
  logic [BcdW-1:0]        bcd, bcd_next;
  logic [BcdW-1:0]        bcd_adj;
  logic [IterW-1:0]       iter, iter_next;
  logic [RemW-1:0]        rem, rem_next;
  logic [2:0]             pidx, pidx_next;
  logic                   valid_next;
  logic [7:0]             char_next;
  logic                   last_next;
  logic [CountW-1:0]      count, count_next;
  logic                   emit;
  logic                   out_free;
  logic [3:0]             top;
  logic [3:0]             d;

  assign out_free = !m_valid || m_ready;
  assign top      = bcd[BcdW-1 -: 4];

  always_comb begin
    for (int i = 0; i < Digs; i++) begin
      d = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    state_next = state;
    ctrl_next  = ctrl;
    bin_next   = bin;
    bcd_next   = bcd;
    iter_next  = iter;
    rem_next   = rem;
    pidx_next  = pidx;
    q_pop      = 1'b0;
    emit       = 1'b0;
    char_next  = m_char;
    last_next  = m_last;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ctrl_next = q_ctrl;
          bin_next  = q_mag;
          rem_next  = RemW'(Digs);
          iter_next = IterW'(VALUE_WIDTH);
          pidx_next = 3'd0;
          case (q_ctrl.kind)
            K_DEC: begin
              bcd_next   = '0;
              state_next = S_CONV;
            end
            K_NIL:   state_next = S_PFX;
            default: begin
              bcd_next   = BcdW'(q_mag);
              state_next = S_SKIP;
            end
          endcase
        end
      end
      S_CONV: begin
        bcd_next  = {bcd_adj[BcdW-2:0], bin[VALUE_WIDTH-1]};
        bin_next  = {bin[VALUE_WIDTH-2:0], 1'b0};
        iter_next = iter - IterW'(1);
        if (iter == IterW'(1)) begin
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top == 4'd0 && rem > RemW'(1)) begin
          bcd_next = {bcd[BcdW-5:0], 4'd0};
          rem_next = rem - RemW'(1);
        end else begin
          state_next = S_PFX;
        end
      end
      S_PFX: begin
        if (pidx == pfx_len(ctrl.kind, ctrl.neg)) begin
          state_next = S_EMIT;
        end else if (out_free) begin
          emit      = 1'b1;
          char_next = pfx_char(ctrl.kind, pidx);
          last_next = (ctrl.kind == K_NIL) && (pidx == 3'd4);
          pidx_next = pidx + 3'd1;
          if (last_next) begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          char_next = hex_char(top, ctrl.upper);
          last_next = (rem == RemW'(1));
          bcd_next  = {bcd[BcdW-5:0], 4'd0};
          rem_next  = rem - RemW'(1);
          if (rem == RemW'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    valid_next = emit || (m_valid && !m_ready);
    count_next = count;
    if (emit && count != COUNT_MAX) begin
      count_next = count + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    ctrl <= ctrl_next;
    bin  <= bin_next;
    bcd  <= bcd_next;
    iter <= iter_next;
    rem  <= rem_next;
    pidx <= pidx_next;
    if (emit) begin
      m_char  <= char_next;
      m_last  <= last_next;
      m_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_valid <= 1'b0;
      count   <= '0;
    end else begin
      state   <= state_next;
      m_valid <= valid_next;
      count   <= count_next;
    end
  end

endmodule

`default_nettype wire

[design/integer_to_ascii_formatter_core.sv]
// channel  dir  tdata                               tuser                      tlast
// s_axis   in   [63:0] value                        [1:0] action, [2] upper    -
// m_axis   out  [7:0] character, [38:8] total_count -                          last char
//
// Per value at 64 bits, decimal takes a pop, VALUE_WIDTH shift-add-3 steps and the 20 digit
// slots, split between dropping leading zeros and emitting (a minus sign, if any, first),
// plus two phase changes. Hex and pointer skip the shift-add-3 steps; "(nil)" is prefix only.
// A 2-beat queue sits between input and converter; output is one register, and a beat
// that waits on m_axis_tready holds the converter whenever it has a character to emit.
// rst is synchronous and clears the queue, sequencer and running count.
`default_nettype none

`include "integer_to_ascii_formatter_core_macros.svh"

module integer_to_ascii_formatter_core
  import itaf_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [63:0] value
  input  wire logic [2:0]  s_axis_tuser,  // [1:0] action, [2] upper_case
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [7:0] character, [38:8] total_count
  output logic             m_axis_tlast
);

  logic                   q_valid;
  itaf_ctrl_t             q_ctrl;
  logic [VALUE_WIDTH-1:0] q_mag;
  logic                   q_pop;
  logic [7:0]             m_char;
  logic [CountW-1:0]      m_count;
  logic                   cnt_beat;
  logic [CountW-1:0]      cnt_inc;

  itaf_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_action (s_axis_tuser[1:0]),
    .s_upper  (s_axis_tuser[2]),
    .s_value  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ctrl   (q_ctrl),
    .q_mag    (q_mag),
    .q_pop    (q_pop)
  );

  itaf_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ctrl  (q_ctrl),
    .q_mag   (q_mag),
    .q_pop   (q_pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_char  (m_char),
    .m_last  (m_axis_tlast),
    .m_count (m_count)
  );

  assign m_axis_tdata = {1'b0, m_count, m_char};

  assign cnt_beat = m_axis_tvalid && m_axis_tready && (m_count != COUNT_MAX);
  assign cnt_inc  = m_count + CountW'(1);

  `ITAF_ASSERT_NOW(a_pop_has_data, q_pop, q_valid, "queue popped while empty")
  `ITAF_ASSERT_NOW(a_count_nonzero, m_axis_tvalid, m_count != '0, "beat with zero count")
  `ITAF_ASSERT_NEXT(a_count_step, cnt_beat, !m_axis_tvalid || m_count == $past(cnt_inc), "count skip")

endmodule

`default_nettype wire

[bench/tb_integer_to_ascii_formatter_core.sv]
`default_nettype none

module tb_integer_to_ascii_formatter_core;
  import itaf_pkg::*;

  localparam int RANDOM_ITEMS = 86;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 40;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_PRINTS = 50;

  typedef struct {
    logic [1:0]  act;
    logic        up;
    logic [63:0] val;
    string       txt;
  } text_row_t;

  typedef struct {
    logic [7:0]        ch;
    logic              last;
    logic [CountW-1:0] count;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  char_beat_t pending_chars[$];
  byte unsigned text_q[$];
  text_row_t dir_rows[$];
  logic [CountW-1:0] chars_emitted = '0;
  int values_sent = 0;
  int beats_checked = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int mode_hits[4] = '{0, 0, 0, 0};
  bit hold_done = 1'b0;

  integer_to_ascii_formatter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, pending_chars.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at beat %0d: %s got %0h want %0h", beats_checked, field, got, want);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Expected text for one value, most significant character first.
  function automatic void render_text(input logic [1:0] act, input logic up,
                                      input logic [63:0] val);
    logic [63:0] mag;
    logic [3:0] nib;
    byte unsigned digs[$];
    text_q.delete();
    mag = val;
    if (act == ACT_SDEC || act == ACT_UDEC) begin
      if (act == ACT_SDEC && mag[63]) begin
        text_q.push_back(CH_MINUS);
        mag = -mag;
      end
      do begin
        digs.push_front(CH_0 + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
    end else if (act == ACT_PTR && mag == 0) begin
      text_q = '{CH_LPAR, CH_N, CH_I, CH_L, CH_RPAR};
    end else begin
      if (act == ACT_PTR) begin
        text_q.push_back(CH_0);
        text_q.push_back(CH_X);
      end
      do begin
        nib = mag[3:0];
        if (nib < 4'd10) digs.push_front(CH_0 + {4'd0, nib});
        else if (act == ACT_HEX && up) digs.push_front(CH_UA + {4'd0, nib} - 8'd10);
        else digs.push_front(CH_LA + {4'd0, nib} - 8'd10);
        mag = mag >> 4;
      end while (mag != 0);
    end
    foreach (digs[i]) text_q.push_back(digs[i]);
  endfunction

  // Turn the current text into expected beats, advancing the running count.
  function automatic void post_text();
    char_beat_t b;
    foreach (text_q[i]) begin
      if (chars_emitted != COUNT_MAX) chars_emitted = chars_emitted + 1'b1;
      b.ch = text_q[i];
      b.last = (i == text_q.size() - 1);
      b.count = chars_emitted;
      pending_chars.push_back(b);
    end
  endfunction

  task automatic send_value(input logic [1:0] act, input logic up, input logic [63:0] val,
                            input string txt);
    int gap;
    gap = idle_len();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= val;
    s_axis_tuser <= {up, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (txt.len() != 0) begin
      text_q.delete();
      for (int i = 0; i < txt.len(); i++) text_q.push_back(txt[i]);
    end else begin
      render_text(act, up, val);
    end
    post_text();
    values_sent++;
    mode_hits[act]++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    char_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch("unexpected beat", 64'({m_axis_tlast, m_axis_tdata}), '0);
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata[7:0] !== want.ch)
          flag_mismatch("character", 64'(m_axis_tdata[7:0]), 64'(want.ch));
        if (m_axis_tlast !== want.last)
          flag_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
        if (m_axis_tdata[38:8] !== want.count)
          flag_mismatch("total_count", 64'(m_axis_tdata[38:8]), 64'(want.count));
        if (m_axis_tdata[39] !== 1'b0)
          flag_mismatch("pad bit", 64'(m_axis_tdata[39]), '0);
      end
      beats_checked++;
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && values_sent >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      begin
        int gap;
        gap = idle_len();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  initial begin
    logic [63:0] val;
    logic [1:0] act;
    logic up;
    int r;
    dir_rows = '{
      '{ACT_SDEC, 1'b0, 64'd0, "0"},
      '{ACT_UDEC, 1'b0, 64'd0, "0"},
      '{ACT_HEX,  1'b1, 64'd0, "0"},
      '{ACT_PTR,  1'b0, 64'd0, "(nil)"},
      '{ACT_PTR,  1'b1, 64'd0, "(nil)"},
      '{ACT_SDEC, 1'b0, 64'h8000_0000_0000_0000, "-9223372036854775808"},
      '{ACT_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff, "9223372036854775807"},
      '{ACT_SDEC, 1'b0, 64'hffff_ffff_ffff_ffff, "-1"},
      '{ACT_SDEC, 1'b0, 64'hffff_ffff_ffff_fff6, "-10"},
      '{ACT_UDEC, 1'b1, 64'hffff_ffff_ffff_ffff, "18446744073709551615"},
      '{ACT_UDEC, 1'b0, 64'h8000_0000_0000_0000, "9223372036854775808"},
      '{ACT_UDEC, 1'b0, 64'd9999999999999999999, ""},
      '{ACT_HEX,  1'b0, 64'hffff_ffff_ffff_ffff, "ffffffffffffffff"},
      '{ACT_HEX,  1'b1, 64'hffff_ffff_ffff_ffff, "FFFFFFFFFFFFFFFF"},
      '{ACT_PTR,  1'b1, 64'hffff_ffff_ffff_ffff, "0xffffffffffffffff"},
      '{ACT_PTR,  1'b0, 64'd1, "0x1"},
      '{ACT_PTR,  1'b1, 64'hdead_beef, ""},
      '{ACT_UDEC, 1'b0, 64'd1, "1"},
      '{ACT_SDEC, 1'b1, 64'd1, "1"},
      '{ACT_UDEC, 1'b0, 64'd10, ""},
      '{ACT_HEX,  1'b1, 64'hab_cdef, ""},
      '{ACT_HEX,  1'b0, 64'hab_cdef, ""},
      '{ACT_HEX,  1'b0, 64'h0123_4567_89ab_cdef, ""},
      '{ACT_SDEC, 1'b0, 64'd1000000, ""}
    };
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_value(dir_rows[i].act, dir_rows[i].up, dir_rows[i].val, dir_rows[i].txt);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      act = 2'($urandom_range(0, 3));
      up = 1'($urandom_range(0, 1));
      val = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 10) val = '0;
      else if (r < 55) val = val >> $urandom_range(1, 63);
      else if (r < 65 && act == ACT_SDEC) val = -(val >> $urandom_range(32, 63));
      send_value(act, up, val, "");
      if (n == RANDOM_ITEMS / 2) wait_drained();
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("formatted %0d values (%0d directed): signed %0d, unsigned %0d, hex %0d, ptr %0d",
             values_sent, dir_rows.size(), mode_hits[ACT_SDEC], mode_hits[ACT_UDEC],
             mode_hits[ACT_HEX], mode_hits[ACT_PTR]);
    $display("%0d character beats checked with output back-pressure, %0d mismatches",
             beats_checked, mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
